// ===== design/heat_diffusion_stencil_2d_macros.svh =====
// Assertion macros shared by the heat diffusion stencil design files.
// Included by files that check their own logic; needs nothing else.
`ifndef HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hds_pkg.sv =====
// Shared types and constants for the heat diffusion stencil block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package hds_pkg;

   // Field and register widths.
   localparam int CELL_W     = 24;
   localparam int GAIN_W     = 16;
   localparam int STEPS_W    = 16;
   localparam int MODE_W     = 2;
   localparam int POS_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Datapath widths: four neighbors minus four times the center, then the gain.
   localparam int LAP_W      = CELL_W + 3;
   localparam int PROD_W     = LAP_W + GAIN_W + 1;
   localparam int FRAC_SHIFT = 16;
   localparam int SUM_W      = PROD_W - FRAC_SHIFT + 1;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS    = 2'd2;

   typedef logic signed [CELL_W-1:0] cell_type;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  GAIN_RESET     = 16'd6554;
   localparam cell_type           BOUNDARY_RESET = 24'sd102400;
   localparam logic [STEPS_W-1:0] STEPS_RESET    = 16'd201;

   // Saturation limits of a cell.
   localparam cell_type CELL_MAX = 24'sh7FFFFF;
   localparam cell_type CELL_MIN = 24'sh800000;

   // Which grid edges the current center cell touches.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } edge_type;

   // The five cells of the stencil as seen in the line window.
   typedef struct packed {
      cell_type center;
      cell_type up;
      cell_type down;
      cell_type west;
      cell_type east;
   } taps_type;

endpackage

// ===== design/hds_bank.sv =====
// One grid bank: a single-write, single-read memory with registered read data.
// Depends on hds_pkg for the cell type.
`timescale 1ns / 1ps
module hds_bank #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  hds_pkg::cell_type   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output hds_pkg::cell_type   rd_data
);

   hds_pkg::cell_type mem_ff [DEPTH];
   hds_pkg::cell_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hds_window.sv =====
// Raster line window: a shift line two rows plus one cell long that presents
// the five stencil taps of the cell one row behind the newest one. Uses hds_pkg.
`timescale 1ns / 1ps
module hds_window #(
   parameter int COLS = 32
) (
   input  logic                clock,
   input  logic                shift_en,
   input  hds_pkg::cell_type   din,
   output hds_pkg::taps_type   taps
);

   localparam int WIN_LEN = 2 * COLS + 1;

   hds_pkg::cell_type win_ff [WIN_LEN];

   // Shift one cell in per valid read.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= din;
         for (int i = 1; i < WIN_LEN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // The newest cell is the lower neighbor of the center; the oldest is the upper one.
   assign taps.down   = win_ff[0];
   assign taps.east   = win_ff[COLS-1];
   assign taps.center = win_ff[COLS];
   assign taps.west   = win_ff[COLS+1];
   assign taps.up     = win_ff[2*COLS];

endmodule

// ===== design/hds_calc.sv =====
// Shared stencil arithmetic: boundary select and Laplacian, gain multiply,
// then shift, add and saturate, one register stage each. Uses hds_pkg.
`timescale 1ns / 1ps
module hds_calc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  hds_pkg::taps_type                   taps,
   input  hds_pkg::edge_type                   edges,
   input  hds_pkg::cell_type                   boundary,
   input  logic [hds_pkg::GAIN_W-1:0]          gain,
   output logic                                out_valid,
   output hds_pkg::cell_type                   out_cell
);

   localparam int LAP_W    = hds_pkg::LAP_W;
   localparam int PROD_W   = hds_pkg::PROD_W;
   localparam int SUM_W    = hds_pkg::SUM_W;
   localparam int CELL_W   = hds_pkg::CELL_W;
   localparam int FRAC     = hds_pkg::FRAC_SHIFT;
   localparam int GAIN_W_S = hds_pkg::GAIN_W + 1;

   hds_pkg::cell_type            up_sel, down_sel, west_sel, east_sel;
   logic signed [LAP_W-1:0]      lap_in;
   logic signed [LAP_W-1:0]      lap_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [GAIN_W_S-1:0]   gain_s;
   hds_pkg::cell_type            ce1_ff, ce2_ff;
   logic signed [SUM_W-1:0]      sum;
   logic [SUM_W-CELL_W:0]        high_bits;
   logic                         ovf;
   hds_pkg::cell_type            sat_in;
   hds_pkg::cell_type            out_cell_ff;
   logic                         v1_ff, v2_ff, v3_ff;

   // Stage one: neighbors outside the grid take the boundary value.
   always_comb begin
      up_sel   = edges.top    ? boundary : taps.up;
      down_sel = edges.bottom ? boundary : taps.down;
      west_sel = edges.left   ? boundary : taps.west;
      east_sel = edges.right  ? boundary : taps.east;
      lap_in   = LAP_W'(up_sel) + LAP_W'(down_sel) + LAP_W'(west_sel) + LAP_W'(east_sel)
                 - (LAP_W'(taps.center) <<< 2);
   end

   always_ff @(posedge clock) begin
      lap_ff <= lap_in;
      ce1_ff <= taps.center;
   end

   // Stage two: gain multiply, gain treated as an unsigned fraction.
   assign gain_s = $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      prod_ff <= lap_ff * gain_s;
      ce2_ff  <= ce1_ff;
   end

   // Stage three: floor shift, add to the center and saturate.
   always_comb begin
      sum       = SUM_W'(ce2_ff) + SUM_W'($signed(prod_ff[PROD_W-1:FRAC]));
      high_bits = sum[SUM_W-1:CELL_W-1];
      ovf       = !((&high_bits) || (~|high_bits));
      if (ovf) begin
         sat_in = sum[SUM_W-1] ? hds_pkg::CELL_MIN : hds_pkg::CELL_MAX;
      end else begin
         sat_in = sum[CELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      out_cell_ff <= sat_in;
   end

   // Valid travels alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_cell  = out_cell_ff;

endmodule

// ===== design/heat_diffusion_stencil_2d.sv =====
// Explicit 2-D heat diffusion on a ROWS x COLS grid of signed Q12.12 cells
// with a five-point stencil. A write request stores one cell and its response
// comes the next cycle, with start taken again at once; a read request keeps
// busy high for one cycle and answers from the read state through the response
// register. A run keeps busy high until the last write of its last step: each
// step streams the live bank through its one read port at one cell per cycle
// into the shared stencil datapath, which writes the other bank, and each step
// also fills the line window and drains the pipeline. A run with a step count
// of zero answers at once. Every request gives exactly one response, shown for
// one cycle on rsp_valid; there is no way to hold it off. Control registers
// may be written only while busy is low. Depends on hds_pkg, hds_bank,
// hds_window, hds_calc and the macros header.
`timescale 1ns / 1ps
`include "heat_diffusion_stencil_2d_macros.svh"
module heat_diffusion_stencil_2d #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [hds_pkg::MODE_W-1:0]            req_mode,
   input  logic [hds_pkg::POS_W-1:0]             req_row,
   input  logic [hds_pkg::POS_W-1:0]             req_col,
   input  logic signed [hds_pkg::CELL_W-1:0]     req_cell_value,
   output logic                                  rsp_valid,
   output logic signed [hds_pkg::CELL_W-1:0]     rsp_read_value,
   output logic                                  rsp_run_done,
   input  logic                                  csr_write_enable,
   input  logic [hds_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int CELLS     = ROWS * COLS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int HOST_W    = ADDR_W + 6;
   localparam int ISSUE_LEN = CELLS + COLS;
   localparam int CNT_W     = $clog2(ISSUE_LEN + 1);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLS);
   localparam int GAIN_W    = hds_pkg::GAIN_W;
   localparam int STEPS_W   = hds_pkg::STEPS_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;

   logic [1:0]               state_ff;
   logic [GAIN_W-1:0]        gain_ff;
   hds_pkg::cell_type        boundary_ff;
   logic [STEPS_W-1:0]       steps_cfg_ff;
   logic [STEPS_W-1:0]       steps_left_ff;
   logic                     bank_ff;
   logic                     read_hit_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [ADDR_W-1:0]        wr_cnt_ff;
   logic [ROW_W-1:0]         ctr_row_ff;
   logic [COL_W-1:0]         ctr_col_ff;
   logic                     feed_v_ff;
   logic                     feed_ctr_ff;
   logic                     win_v_ff;
   logic                     rsp_valid_ff;
   hds_pkg::cell_type        rsp_read_value_ff;
   logic                     rsp_run_done_ff;

   logic                     accept;
   logic [HOST_W-1:0]        host_wide;
   logic                     host_hit;
   logic [ADDR_W-1:0]        host_addr;
   logic                     host_we;
   logic                     issue_active;
   logic [ADDR_W-1:0]        stream_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     we_a, we_b;
   logic [ADDR_W-1:0]        wr_addr;
   hds_pkg::cell_type        wr_data;
   hds_pkg::cell_type        rdata_a, rdata_b, src_rdata;
   hds_pkg::taps_type        taps;
   hds_pkg::edge_type        edges;
   logic                     run_we;
   hds_pkg::cell_type        res_cell;
   logic                     step_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= hds_pkg::GAIN_RESET;
         boundary_ff  <= hds_pkg::BOUNDARY_RESET;
         steps_cfg_ff <= hds_pkg::STEPS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hds_pkg::CSR_GAIN:     gain_ff      <= csr_data[GAIN_W-1:0];
            hds_pkg::CSR_BOUNDARY: boundary_ff  <= csr_data;
            hds_pkg::CSR_STEPS:    steps_cfg_ff <= csr_data[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Host cell address and grid range check.
   always_comb begin
      host_wide = HOST_W'(req_row) * HOST_W'(COLS) + HOST_W'(req_col);
      host_hit  = (HOST_W'(req_row) < HOST_W'(ROWS)) && (HOST_W'(req_col) < HOST_W'(COLS));
      host_addr = host_wide[ADDR_W-1:0];
      host_we   = accept && (req_mode == hds_pkg::MODE_WRITE) && host_hit;
   end

   // Raster stream of the live bank during a step.
   always_comb begin
      issue_active = (state_ff == ST_STEP) && (cnt_ff < CNT_W'(ISSUE_LEN));
      stream_addr  = (cnt_ff < CNT_W'(CELLS)) ? cnt_ff[ADDR_W-1:0] : '0;
      rd_addr      = (state_ff == ST_STEP) ? stream_addr : host_addr;
   end

   // Bank write steering: host writes the live bank, a step writes the other.
   always_comb begin
      we_a      = (host_we && !bank_ff) || (run_we && bank_ff);
      we_b      = (host_we && bank_ff) || (run_we && !bank_ff);
      wr_addr   = run_we ? wr_cnt_ff : host_addr;
      wr_data   = run_we ? res_cell : req_cell_value;
      src_rdata = bank_ff ? rdata_b : rdata_a;
      step_last = run_we && (wr_cnt_ff == ADDR_W'(CELLS - 1));
   end

   hds_bank #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_bank_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_a)
   );

   hds_bank #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_bank_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_b)
   );

   hds_window #(
      .COLS (COLS)
   ) u_window (
      .clock    (clock),
      .shift_en (feed_v_ff),
      .din      (src_rdata),
      .taps     (taps)
   );

   // Edge flags of the center cell now in the window.
   always_comb begin
      edges.top    = (ctr_row_ff == '0);
      edges.bottom = (ctr_row_ff == ROW_W'(ROWS - 1));
      edges.left   = (ctr_col_ff == '0);
      edges.right  = (ctr_col_ff == COL_W'(COLS - 1));
   end

   hds_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_v_ff),
      .taps      (taps),
      .edges     (edges),
      .boundary  (boundary_ff),
      .gain      (gain_ff),
      .out_valid (run_we),
      .out_cell  (res_cell)
   );

   // Feed tracking: a center is ready once a full row sits behind the newest cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_v_ff   <= 1'b0;
         feed_ctr_ff <= 1'b0;
         win_v_ff    <= 1'b0;
      end else begin
         feed_v_ff   <= issue_active;
         feed_ctr_ff <= (cnt_ff >= CNT_W'(COLS));
         win_v_ff    <= feed_v_ff && feed_ctr_ff;
      end
   end

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bank_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= '0;
         wr_cnt_ff       <= '0;
         ctr_row_ff      <= '0;
         ctr_col_ff      <= '0;
         steps_left_ff   <= '0;
         read_hit_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cnt_ff     <= '0;
                  wr_cnt_ff  <= '0;
                  ctr_row_ff <= '0;
                  ctr_col_ff <= '0;
                  unique case (req_mode)
                     hds_pkg::MODE_READ: begin
                        read_hit_ff <= host_hit;
                        state_ff    <= ST_READ;
                     end
                     hds_pkg::MODE_RUN: begin
                        if (steps_cfg_ff == '0) begin
                           rsp_valid_ff      <= 1'b1;
                           rsp_read_value_ff <= '0;
                           rsp_run_done_ff   <= 1'b1;
                        end else begin
                           steps_left_ff <= steps_cfg_ff;
                           state_ff      <= ST_STEP;
                        end
                     end
                     default: begin
                        rsp_valid_ff      <= 1'b1;
                        rsp_read_value_ff <= '0;
                        rsp_run_done_ff   <= 1'b0;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff      <= 1'b1;
               rsp_read_value_ff <= read_hit_ff ? src_rdata : '0;
               rsp_run_done_ff   <= 1'b0;
               state_ff          <= ST_IDLE;
            end
            ST_STEP: begin
               if (issue_active) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (win_v_ff) begin
                  if (ctr_col_ff == COL_W'(COLS - 1)) begin
                     ctr_col_ff <= '0;
                     ctr_row_ff <= (ctr_row_ff == ROW_W'(ROWS - 1)) ? '0 : ctr_row_ff + 1'b1;
                  end else begin
                     ctr_col_ff <= ctr_col_ff + 1'b1;
                  end
               end
               if (run_we) begin
                  wr_cnt_ff <= wr_cnt_ff + 1'b1;
               end
               // End of one time step: flip banks, then restart or finish.
               if (step_last) begin
                  bank_ff       <= !bank_ff;
                  steps_left_ff <= steps_left_ff - 1'b1;
                  cnt_ff        <= '0;
                  wr_cnt_ff     <= '0;
                  ctr_row_ff    <= '0;
                  ctr_col_ff    <= '0;
                  if (steps_left_ff == STEPS_W'(1)) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_read_value_ff <= '0;
                     rsp_run_done_ff   <= 1'b1;
                     state_ff          <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_run_done   = rsp_run_done_ff;

   // Checks on bank steering, step sequencing and responses.
   `HDS_ASSERT_SAME(a_step_writes_idle_bank, clock, reset, run_we, (we_a == bank_ff) && (we_b == !bank_ff), "step write hit the live bank")
   `HDS_ASSERT_NEXT(a_bank_flips_per_step, clock, reset, step_last, bank_ff != $past(bank_ff), "bank did not flip after a step")
   `HDS_ASSERT_SAME(a_step_write_in_grid, clock, reset, run_we, (state_ff == ST_STEP) && (wr_cnt_ff <= ADDR_W'(CELLS - 1)), "step write outside the grid or outside a run")
   `HDS_ASSERT_NEXT(a_run_goes_busy, clock, reset, accept && (req_mode == hds_pkg::MODE_RUN) && (steps_cfg_ff != '0), busy, "run request did not start")
   `HDS_ASSERT_SAME(a_rsp_one_kind, clock, reset, rsp_valid && rsp_run_done, rsp_read_value == '0, "run response carries a read value")

endmodule
